// ----- rtl/gregorian_date_arithmetic_top_macros.svh -----
`ifndef GREGORIAN_DATE_ARITHMETIC_TOP_MACROS_SVH
`define GREGORIAN_DATE_ARITHMETIC_TOP_MACROS_SVH

// same-cycle implication
`define GDA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gda_pkg.sv -----
package gda_pkg;

    localparam int ORD_W     = 24;
    localparam int MB_W      = 18;
    localparam int RES_W     = ORD_W + MB_W;
    localparam int RCP_SHIFT = 23;

    localparam logic [MB_W-1:0] RCP100    = 18'd83887;
    localparam logic [MB_W-1:0] CENT      = 18'd100;
    localparam logic [MB_W-1:0] YEAR_DAYS = 18'd365;
    localparam logic [MB_W-1:0] QUAD_CENT = 18'd400;

    localparam logic signed [ORD_W:0] DIFF_MAX = 25'sd4194303;
    localparam logic signed [ORD_W:0] DIFF_MIN = -25'sd4194304;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ORD_W-1:0] a;
        logic [ORD_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [RES_W-1:0] res;
        logic             ge;
    } alu_rsp_t;

    typedef struct packed {
        logic        valid;
        logic        leap;
        logic [12:0] ofs;
    } date_info_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        FUNC_ADD  = 1'b0,
        FUNC_DIFF = 1'b1
    } func_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // divisors of the 400-year, century, 4-year and year levels
    function automatic logic [MB_W-1:0] div_const(input logic [1:0] lvl);
        logic [MB_W-1:0] v;
        case (lvl)
            2'd0:    v = 18'd146097;
            2'd1:    v = 18'd36524;
            2'd2:    v = 18'd1461;
            default: v = 18'd365;
        endcase
        return v;
    endfunction

    // floor(2^23 / divisor)
    function automatic logic [MB_W-1:0] div_rcp(input logic [1:0] lvl);
        logic [MB_W-1:0] v;
        case (lvl)
            2'd0:    v = 18'd57;
            2'd1:    v = 18'd229;
            2'd2:    v = 18'd5741;
            default: v = 18'd22982;
        endcase
        return v;
    endfunction

    function automatic logic div_capped(input logic [1:0] lvl);
        return (lvl == 2'd1) || (lvl == 2'd3);
    endfunction

endpackage

// ----- rtl/gda_alu.sv -----
module gda_alu (
    input  gda_pkg::alu_req_t req,
    output gda_pkg::alu_rsp_t rsp
);
    import gda_pkg::*;

    logic [ORD_W:0]   diff;
    logic [RES_W-1:0] prod;

    always_comb
    begin
        diff   = {1'b0, req.a} - {1'b0, req.b};
        prod   = req.a * req.b[MB_W-1:0];
        rsp.ge = ~diff[ORD_W];
        case (req.op)
            ALU_ADD: rsp.res = RES_W'(req.a) + RES_W'(req.b);
            ALU_SUB: rsp.res = {{(RES_W-ORD_W-1){diff[ORD_W]}}, diff};
            ALU_MUL: rsp.res = prod;
            default: rsp.res = '0;
        endcase
    end

endmodule

// ----- rtl/gda_date.sv -----
module gda_date #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic [4:0]          d,
    input  logic [3:0]          m,
    input  logic [13:0]         y,
    input  logic [7:0]          q100,
    input  logic                y100,
    output gda_pkg::date_info_t info
);
    import gda_pkg::*;

    logic [13:0] p;
    logic [7:0]  p100;
    logic [12:0] corr;
    logic [8:0]  doy;
    logic        leap;
    logic [4:0]  mlen;
    logic        m_ok;
    logic        y_ok;
    logic        d_ok;

    always_comb
    begin
        p    = y - 14'd1;
        p100 = q100 - 8'(y100);
        leap = ((y[1:0] == 2'b00) && !y100) || (y100 && (q100[1:0] == 2'b00));
        mlen = month_len(m, leap);
        m_ok = (m >= 4'd1) && (m <= 4'd12);
        y_ok = (y != 14'd0) && (32'(y) <= MAX_YEAR);
        d_ok = (d != 5'd0) && (d <= mlen);
        // leap days of the years before this one
        corr = 13'(p[13:2]) - 13'(p100) + 13'(p100[7:2]);
        doy  = days_before(m) + 9'(leap && (m > 4'd2)) + 9'(d);
        info.valid = m_ok && y_ok && d_ok;
        info.leap  = leap;
        info.ofs   = corr + 13'(doy) - 13'd1;
    end

endmodule

// ----- rtl/gregorian_date_arithmetic_top.sv -----
// Gregorian date add and difference unit.
// A transaction is accepted on a rising edge with start high and busy low; the
// operands (func, day_a, month_a, year_a, day_b, month_b, year_b, count_k) are
// captured then and need not be held afterwards. busy stays high until the result
// is out. done is high for exactly one cycle with the result on day_out, month_out,
// year_out, days_between and status; the receiver cannot stall, so the result must
// be taken in that cycle. A new transaction may be started in the done cycle.
// One multiplier/adder is shared by every step under the sequencer, which runs
// its steps in this order, from the accept edge to the done cycle:
//   difference: year/100 and the ordinal of date A, then of date B, 1 subtract
//   add: the ordinal of date A and the add of count_k, four constant divisions at
//        4 steps each, the year, 1 to 12 month steps
//   invalid date A or B: the transaction ends once that date has been checked
// No new transaction is taken while busy. Reset clears the sequencer to idle
// with done low; no transaction is lost other than one in flight.
`include "gregorian_date_arithmetic_top_macros.svh"

module gregorian_date_arithmetic_top #(
    parameter int unsigned MAX_YEAR = 9999,
    parameter int unsigned MAX_STEP = 1048575
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic [4:0]         day_a,
    input  logic [3:0]         month_a,
    input  logic [13:0]        year_a,
    input  logic [4:0]         day_b,
    input  logic [3:0]         month_b,
    input  logic [13:0]        year_b,
    input  logic [19:0]        count_k,
    output logic               done,
    output logic [4:0]         day_out,
    output logic [3:0]         month_out,
    output logic [13:0]        year_out,
    output logic signed [22:0] days_between,
    output logic [1:0]         status
);
    import gda_pkg::*;

    localparam logic [15:0]      MAX_YEAR_W = 16'(MAX_YEAR);
    localparam logic [ORD_W-1:0] MAX_STEP_W = ORD_W'(MAX_STEP);

    typedef enum logic [3:0] {
        S_IDLE,
        S_YQ,
        S_YH,
        S_YD,
        S_ORD,
        S_ADDK,
        S_DEST,
        S_DBACK,
        S_DREM,
        S_DFIX,
        S_YEAR,
        S_YADD,
        S_MSTEP,
        S_DIFF
    } state_t;

    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic [4:0]         da_reg, da_next;
    logic [3:0]         ma_reg, ma_next;
    logic [13:0]        ya_reg, ya_next;
    logic [4:0]         db_reg, db_next;
    logic [3:0]         mb_reg, mb_next;
    logic [13:0]        yb_reg, yb_next;
    logic [19:0]        kk_reg, kk_next;
    logic               which_reg, which_next;
    logic [7:0]         q100_reg, q100_next;
    logic               y100_reg, y100_next;
    logic [ORD_W-1:0]   acc_reg, acc_next;
    logic [ORD_W-1:0]   orda_reg, orda_next;
    logic [ORD_W-1:0]   r_reg, r_next;
    logic [6:0]         qt_reg, qt_next;
    logic [1:0]         lvl_reg, lvl_next;
    logic [6:0]         q400_reg, q400_next;
    logic [1:0]         cen_reg, cen_next;
    logic [4:0]         q4_reg, q4_next;
    logic [1:0]         y1_reg, y1_next;
    logic [3:0]         mon_reg, mon_next;
    logic [15:0]        yr_reg, yr_next;
    logic               done_reg, done_next;
    logic [4:0]         day_out_reg, day_out_next;
    logic [3:0]         month_out_reg, month_out_next;
    logic [13:0]        year_out_reg, year_out_next;
    logic signed [22:0] between_reg, between_next;
    status_t            status_reg, status_next;

    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;
    date_info_t         info;
    logic [4:0]         d_sel;
    logic [3:0]         m_sel;
    logic [13:0]        y_sel;
    logic               leap_o;
    logic [MB_W-1:0]    dcon;
    logic [MB_W-1:0]    drcp;
    logic               can_fix;
    logic [6:0]         qsel;
    logic [8:0]         ysmall;
    logic signed [ORD_W:0] dsg;
    logic [ORD_W-1:0]   fix_bound;

    gda_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    gda_date #(
        .MAX_YEAR (MAX_YEAR)
    ) u_date (
        .d    (d_sel),
        .m    (m_sel),
        .y    (y_sel),
        .q100 (q100_reg),
        .y100 (y100_reg),
        .info (info)
    );

    always_comb
    begin
        d_sel     = which_reg ? db_reg : da_reg;
        m_sel     = which_reg ? mb_reg : ma_reg;
        y_sel     = which_reg ? yb_reg : ya_reg;
        leap_o    = (y1_reg == 2'd3) && ((q4_reg != 5'd24) || (cen_reg == 2'd3));
        dcon      = div_const(lvl_reg);
        drcp      = div_rcp(lvl_reg);
        fix_bound = ORD_W'({dcon, 1'b0});
        can_fix   = alu_rsp.ge && !(div_capped(lvl_reg) && (qt_reg == 7'd3));
        qsel      = can_fix ? (qt_reg + 7'd1) : qt_reg;
        ysmall    = 9'(cen_reg) * 9'd100 + {2'b00, q4_reg, 2'b00} + 9'(y1_reg) + 9'd1;
        dsg       = alu_rsp.res[ORD_W:0];

        state_next     = state_reg;
        func_next      = func_reg;
        da_next        = da_reg;
        ma_next        = ma_reg;
        ya_next        = ya_reg;
        db_next        = db_reg;
        mb_next        = mb_reg;
        yb_next        = yb_reg;
        kk_next        = kk_reg;
        which_next     = which_reg;
        q100_next      = q100_reg;
        y100_next      = y100_reg;
        acc_next       = acc_reg;
        orda_next      = orda_reg;
        r_next         = r_reg;
        qt_next        = qt_reg;
        lvl_next       = lvl_reg;
        q400_next      = q400_reg;
        cen_next       = cen_reg;
        q4_next        = q4_reg;
        y1_next        = y1_reg;
        mon_next       = mon_reg;
        yr_next        = yr_reg;
        done_next      = 1'b0;
        day_out_next   = day_out_reg;
        month_out_next = month_out_reg;
        year_out_next  = year_out_reg;
        between_next   = between_reg;
        status_next    = status_reg;

        alu_req.op = ALU_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func_t'(func);
                    da_next    = day_a;
                    ma_next    = month_a;
                    ya_next    = year_a;
                    db_next    = day_b;
                    mb_next    = month_b;
                    yb_next    = year_b;
                    kk_next    = (ORD_W'(count_k) > MAX_STEP_W) ? MAX_STEP_W[19:0] : count_k;
                    which_next = 1'b0;
                    state_next = S_YQ;
                end
            end
            S_YQ:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = ORD_W'(y_sel);
                alu_req.b  = ORD_W'(RCP100);
                q100_next  = alu_rsp.res[RCP_SHIFT+7:RCP_SHIFT];
                state_next = S_YH;
            end
            S_YH:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = ORD_W'(q100_reg);
                alu_req.b  = ORD_W'(CENT);
                y100_next  = (alu_rsp.res[15:0] == 16'(y_sel));
                state_next = S_YD;
            end
            S_YD:
            begin
                if (!info.valid)
                begin
                    status_next    = STATUS_INVALID;
                    day_out_next   = '0;
                    month_out_next = '0;
                    year_out_next  = '0;
                    between_next   = '0;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    alu_req.op = ALU_MUL;
                    alu_req.a  = ORD_W'(y_sel - 14'd1);
                    alu_req.b  = ORD_W'(YEAR_DAYS);
                    acc_next   = alu_rsp.res[ORD_W-1:0];
                    state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = acc_reg;
                alu_req.b  = ORD_W'(info.ofs);
                if (!which_reg && (func_reg == FUNC_DIFF))
                begin
                    orda_next  = alu_rsp.res[ORD_W-1:0];
                    which_next = 1'b1;
                    state_next = S_YQ;
                end
                else
                begin
                    acc_next   = alu_rsp.res[ORD_W-1:0];
                    state_next = which_reg ? S_DIFF : S_ADDK;
                end
            end
            S_ADDK:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = acc_reg;
                alu_req.b  = ORD_W'(kk_reg);
                r_next     = alu_rsp.res[ORD_W-1:0];
                lvl_next   = 2'd0;
                state_next = S_DEST;
            end
            S_DEST:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = r_reg;
                alu_req.b  = ORD_W'(drcp);
                qt_next    = alu_rsp.res[RCP_SHIFT+6:RCP_SHIFT];
                state_next = S_DBACK;
            end
            S_DBACK:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = ORD_W'(qt_reg);
                alu_req.b  = ORD_W'(dcon);
                acc_next   = alu_rsp.res[ORD_W-1:0];
                state_next = S_DREM;
            end
            S_DREM:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r_reg;
                alu_req.b  = acc_reg;
                r_next     = alu_rsp.res[ORD_W-1:0];
                state_next = S_DFIX;
            end
            S_DFIX:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r_reg;
                alu_req.b  = ORD_W'(dcon);
                if (can_fix)
                begin
                    r_next = alu_rsp.res[ORD_W-1:0];
                end
                case (lvl_reg)
                    2'd0:    q400_next = qsel;
                    2'd1:    cen_next  = qsel[1:0];
                    2'd2:    q4_next   = qsel[4:0];
                    default: y1_next   = qsel[1:0];
                endcase
                if (lvl_reg == 2'd3)
                begin
                    state_next = S_YEAR;
                end
                else
                begin
                    lvl_next   = lvl_reg + 2'd1;
                    state_next = S_DEST;
                end
            end
            S_YEAR:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = ORD_W'(q400_reg);
                alu_req.b  = ORD_W'(QUAD_CENT);
                acc_next   = alu_rsp.res[ORD_W-1:0];
                state_next = S_YADD;
            end
            S_YADD:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = acc_reg;
                alu_req.b  = ORD_W'(ysmall);
                yr_next    = alu_rsp.res[15:0];
                mon_next   = 4'd1;
                state_next = S_MSTEP;
            end
            S_MSTEP:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r_reg;
                alu_req.b  = ORD_W'(month_len(mon_reg, leap_o));
                if (alu_rsp.ge)
                begin
                    r_next   = alu_rsp.res[ORD_W-1:0];
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    between_next = '0;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                    if (yr_reg > MAX_YEAR_W)
                    begin
                        status_next    = STATUS_OVERFLOW;
                        day_out_next   = '0;
                        month_out_next = '0;
                        year_out_next  = '0;
                    end
                    else
                    begin
                        status_next    = STATUS_OK;
                        day_out_next   = r_reg[4:0] + 5'd1;
                        month_out_next = mon_reg;
                        year_out_next  = yr_reg[13:0];
                    end
                end
            end
            S_DIFF:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = orda_reg;
                alu_req.b  = acc_reg;
                if (dsg > DIFF_MAX)
                begin
                    between_next = DIFF_MAX[22:0];
                end
                else if (dsg < DIFF_MIN)
                begin
                    between_next = DIFF_MIN[22:0];
                end
                else
                begin
                    between_next = dsg[22:0];
                end
                status_next    = STATUS_OK;
                day_out_next   = '0;
                month_out_next = '0;
                year_out_next  = '0;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= FUNC_ADD;
            da_reg        <= '0;
            ma_reg        <= '0;
            ya_reg        <= '0;
            db_reg        <= '0;
            mb_reg        <= '0;
            yb_reg        <= '0;
            kk_reg        <= '0;
            which_reg     <= 1'b0;
            q100_reg      <= '0;
            y100_reg      <= 1'b0;
            acc_reg       <= '0;
            orda_reg      <= '0;
            r_reg         <= '0;
            qt_reg        <= '0;
            lvl_reg       <= '0;
            q400_reg      <= '0;
            cen_reg       <= '0;
            q4_reg        <= '0;
            y1_reg        <= '0;
            mon_reg       <= 4'd1;
            yr_reg        <= '0;
            done_reg      <= 1'b0;
            day_out_reg   <= '0;
            month_out_reg <= '0;
            year_out_reg  <= '0;
            between_reg   <= '0;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            da_reg        <= da_next;
            ma_reg        <= ma_next;
            ya_reg        <= ya_next;
            db_reg        <= db_next;
            mb_reg        <= mb_next;
            yb_reg        <= yb_next;
            kk_reg        <= kk_next;
            which_reg     <= which_next;
            q100_reg      <= q100_next;
            y100_reg      <= y100_next;
            acc_reg       <= acc_next;
            orda_reg      <= orda_next;
            r_reg         <= r_next;
            qt_reg        <= qt_next;
            lvl_reg       <= lvl_next;
            q400_reg      <= q400_next;
            cen_reg       <= cen_next;
            q4_reg        <= q4_next;
            y1_reg        <= y1_next;
            mon_reg       <= mon_next;
            yr_reg        <= yr_next;
            done_reg      <= done_next;
            day_out_reg   <= day_out_next;
            month_out_reg <= month_out_next;
            year_out_reg  <= year_out_next;
            between_reg   <= between_next;
            status_reg    <= status_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign day_out      = day_out_reg;
    assign month_out    = month_out_reg;
    assign year_out     = year_out_reg;
    assign days_between = between_reg;
    assign status       = status_reg;

    `GDA_ASSERT_SAME(a_done_in_idle, clk, rst_n, done_reg, state_reg == S_IDLE, "result strobe while sequencer active")
    `GDA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted transaction did not start")
    `GDA_ASSERT_SAME(a_rem_bound, clk, rst_n, state_reg == S_DFIX, r_reg < fix_bound, "quotient estimate off by more than one")
    `GDA_ASSERT_SAME(a_month_range, clk, rst_n, state_reg == S_MSTEP, (mon_reg >= 4'd1) && (mon_reg <= 4'd12), "month step out of range")

endmodule

// ----- bench/gregorian_date_arithmetic_top_tb.sv -----
module gregorian_date_arithmetic_top_tb;

    import gda_pkg::*;

    localparam int unsigned YEAR_LIMIT   = 9999;
    localparam int unsigned STEP_LIMIT   = 1048575;
    localparam int unsigned RANDOM_ITEMS = 1950;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam longint      SPAN_HI      = 4194303;
    localparam longint      SPAN_LO      = -4194304;

    typedef struct {
        func_t       func;
        logic [4:0]  day_a;
        logic [3:0]  month_a;
        logic [13:0] year_a;
        logic [4:0]  day_b;
        logic [3:0]  month_b;
        logic [13:0] year_b;
        logic [19:0] count_k;
    } date_request_t;

    typedef struct {
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
        logic signed [22:0] span;
        status_t            status;
    } date_result_t;

    class date_scoreboard;
        date_result_t expected_dates[$];
        int unsigned  mismatches;
        int unsigned  add_count;
        int unsigned  diff_count;
        int unsigned  invalid_count;
        int unsigned  overflow_count;

        function bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned days_in_month(int unsigned m, int unsigned y);
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            if (m == 2)
                return is_leap(y) ? 29 : 28;
            return 31;
        endfunction

        function bit date_ok(int unsigned d, int unsigned m, int unsigned y);
            if (m < 1 || m > 12 || y < 1 || y > YEAR_LIMIT)
                return 1'b0;
            return d >= 1 && d <= days_in_month(m, y);
        endfunction

        // 0001-01-01 is day 1
        function int unsigned day_number(int unsigned d, int unsigned m, int unsigned y);
            int unsigned p;
            int unsigned n;
            p = y - 1;
            n = 365 * p + p / 4 - p / 100 + p / 400;
            for (int unsigned i = 1; i < m; i++)
                n += days_in_month(i, y);
            return n + d;
        endfunction

        function void date_of_number(input int unsigned n, output int unsigned d,
                                     output int unsigned m, output int unsigned y);
            int unsigned rem;
            rem = n - 1;
            y = 1 + 400 * (rem / 146097);
            rem = rem % 146097;
            while (rem >= (is_leap(y) ? 366 : 365))
            begin
                rem -= is_leap(y) ? 366 : 365;
                y++;
            end
            m = 1;
            while (rem >= days_in_month(m, y))
            begin
                rem -= days_in_month(m, y);
                m++;
            end
            d = rem + 1;
        endfunction

        function date_result_t predict_date_result(date_request_t rq);
            date_result_t r;
            int unsigned  steps;
            int unsigned  d;
            int unsigned  m;
            int unsigned  y;
            int unsigned  na;
            int unsigned  nb;
            longint       span;
            r.day    = '0;
            r.month  = '0;
            r.year   = '0;
            r.span   = '0;
            r.status = STATUS_OK;
            if (rq.func == FUNC_ADD)
            begin
                if (!date_ok(32'(rq.day_a), 32'(rq.month_a), 32'(rq.year_a)))
                    r.status = STATUS_INVALID;
                else
                begin
                    steps = (32'(rq.count_k) > STEP_LIMIT) ? STEP_LIMIT : 32'(rq.count_k);
                    na = day_number(32'(rq.day_a), 32'(rq.month_a), 32'(rq.year_a));
                    date_of_number(na + steps, d, m, y);
                    if (y > YEAR_LIMIT)
                        r.status = STATUS_OVERFLOW;
                    else
                    begin
                        r.day   = 5'(d);
                        r.month = 4'(m);
                        r.year  = 14'(y);
                    end
                end
            end
            else
            begin
                if (!date_ok(32'(rq.day_a), 32'(rq.month_a), 32'(rq.year_a)) ||
                    !date_ok(32'(rq.day_b), 32'(rq.month_b), 32'(rq.year_b)))
                    r.status = STATUS_INVALID;
                else
                begin
                    na = day_number(32'(rq.day_a), 32'(rq.month_a), 32'(rq.year_a));
                    nb = day_number(32'(rq.day_b), 32'(rq.month_b), 32'(rq.year_b));
                    span = longint'(na) - longint'(nb);
                    if (span > SPAN_HI)
                        span = SPAN_HI;
                    if (span < SPAN_LO)
                        span = SPAN_LO;
                    r.span = span[22:0];
                end
            end
            return r;
        endfunction

        function void note_request(date_request_t rq);
            date_result_t r;
            r = predict_date_result(rq);
            if (rq.func == FUNC_ADD)
                add_count++;
            else
                diff_count++;
            if (r.status == STATUS_INVALID)
                invalid_count++;
            if (r.status == STATUS_OVERFLOW)
                overflow_count++;
            expected_dates.push_back(r);
        endfunction

        function void compare_field(string label, longint want, longint seen);
            if (want != seen)
            begin
                mismatches++;
                $display("%0t: %s expected %0d actual %0d", $time, label, want, seen);
            end
        endfunction

        function void check_result(date_result_t got);
            date_result_t want;
            if (expected_dates.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, status %0d", $time, got.status);
                return;
            end
            want = expected_dates.pop_front();
            compare_field("day_out", longint'(want.day), longint'(got.day));
            compare_field("month_out", longint'(want.month), longint'(got.month));
            compare_field("year_out", longint'(want.year), longint'(got.year));
            compare_field("days_between", longint'(want.span), longint'(got.span));
            compare_field("status", longint'(want.status), longint'(got.status));
        endfunction

        function int unsigned outstanding();
            return expected_dates.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               func;
    logic [4:0]         day_a;
    logic [3:0]         month_a;
    logic [13:0]        year_a;
    logic [4:0]         day_b;
    logic [3:0]         month_b;
    logic [13:0]        year_b;
    logic [19:0]        count_k;
    logic               done;
    logic [4:0]         day_out;
    logic [3:0]         month_out;
    logic [13:0]        year_out;
    logic signed [22:0] days_between;
    logic [1:0]         status;

    date_scoreboard board = new();
    int unsigned    cycle_count = 0;

    gregorian_date_arithmetic_top #(
        .MAX_YEAR(YEAR_LIMIT),
        .MAX_STEP(STEP_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .day_a(day_a),
        .month_a(month_a),
        .year_a(year_a),
        .day_b(day_b),
        .month_b(month_b),
        .year_b(year_b),
        .count_k(count_k),
        .done(done),
        .day_out(day_out),
        .month_out(month_out),
        .year_out(year_out),
        .days_between(days_between),
        .status(status)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("gregorian_date_arithmetic_top verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        date_result_t got;
        if (rst_n && done)
        begin
            got.day    = day_out;
            got.month  = month_out;
            got.year   = year_out;
            got.span   = days_between;
            got.status = status_t'(status);
            board.check_result(got);
        end
    end

    task automatic apply_request(input date_request_t rq);
        @(negedge clk);
        start   = 1'b1;
        func    = rq.func;
        day_a   = rq.day_a;
        month_a = rq.month_a;
        year_a  = rq.year_a;
        day_b   = rq.day_b;
        month_b = rq.month_b;
        year_b  = rq.year_b;
        count_k = rq.count_k;
        do
            @(posedge clk);
        while (busy);
        board.note_request(rq);
    endtask

    // operands are don't-care while start is low
    task automatic idle_cycles(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            start   = 1'b0;
            func    = 1'($urandom_range(0, 1));
            day_a   = 5'($urandom);
            month_a = 4'($urandom);
            year_a  = 14'($urandom);
            day_b   = 5'($urandom);
            month_b = 4'($urandom);
            year_b  = 14'($urandom);
            count_k = 20'($urandom);
        end
    endtask

    task automatic send_fields(input func_t f, input int unsigned da, input int unsigned ma,
                               input int unsigned ya, input int unsigned db,
                               input int unsigned mb, input int unsigned yb,
                               input int unsigned k);
        date_request_t rq;
        rq.func    = f;
        rq.day_a   = 5'(da);
        rq.month_a = 4'(ma);
        rq.year_a  = 14'(ya);
        rq.day_b   = 5'(db);
        rq.month_b = 4'(mb);
        rq.year_b  = 14'(yb);
        rq.count_k = 20'(k);
        apply_request(rq);
    endtask

    function automatic void pick_valid_date(output logic [4:0] d, output logic [3:0] m,
                                            output logic [13:0] y);
        int unsigned len;
        case ($urandom_range(0, 9))
            0:       y = 14'($urandom_range(9990, 9999));
            1:       y = 14'($urandom_range(1, 8));
            2:       y = 14'($urandom_range(1, 99) * 100);
            default: y = 14'($urandom_range(1, 9999));
        endcase
        m   = 4'($urandom_range(1, 12));
        len = board.days_in_month(32'(m), 32'(y));
        d   = 5'($urandom_range(0, 1) ? len - $urandom_range(0, 1) : $urandom_range(1, len));
    endfunction

    function automatic void pick_raw_date(output logic [4:0] d, output logic [3:0] m,
                                          output logic [13:0] y);
        d = 5'($urandom);
        m = 4'($urandom);
        y = 14'($urandom);
    endfunction

    function automatic date_request_t random_request();
        date_request_t rq;
        int unsigned   sel;
        sel     = $urandom_range(0, 99);
        rq.func = func_t'($urandom_range(0, 1));
        pick_valid_date(rq.day_a, rq.month_a, rq.year_a);
        pick_valid_date(rq.day_b, rq.month_b, rq.year_b);
        case ($urandom_range(0, 4))
            0:       rq.count_k = 20'($urandom_range(0, 31));
            1:       rq.count_k = 20'($urandom_range(0, 400));
            2:       rq.count_k = 20'($urandom_range(0, 40000));
            3:       rq.count_k = 20'(STEP_LIMIT - $urandom_range(0, 10));
            default: rq.count_k = 20'($urandom);
        endcase
        if (sel >= 92)
        begin
            pick_raw_date(rq.day_a, rq.month_a, rq.year_a);
            pick_raw_date(rq.day_b, rq.month_b, rq.year_b);
            rq.count_k = 20'($urandom);
        end
        else if (sel >= 82)
        begin
            if ($urandom_range(0, 1))
                pick_raw_date(rq.day_a, rq.month_a, rq.year_a);
            else
                pick_raw_date(rq.day_b, rq.month_b, rq.year_b);
        end
        return rq;
    endfunction

    task automatic drain_results();
        while (board.outstanding() != 0)
            idle_cycles(1);
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        func    = 1'b0;
        day_a   = '0;
        month_a = '0;
        year_a  = '0;
        day_b   = '0;
        month_b = '0;
        year_b  = '0;
        count_k = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // add: range ends, leap rules, overflow
        send_fields(FUNC_ADD, 1, 1, 1, 0, 0, 0, 0);
        send_fields(FUNC_ADD, 31, 12, 9999, 31, 15, 16383, 0);
        send_fields(FUNC_ADD, 31, 12, 9999, 0, 0, 0, 1);
        send_fields(FUNC_ADD, 1, 1, 1, 0, 0, 0, 'hFFFFF);
        send_fields(FUNC_ADD, 1, 1, 9999, 0, 0, 0, 'hFFFFF);
        send_fields(FUNC_ADD, 28, 2, 2000, 0, 0, 0, 1);
        send_fields(FUNC_ADD, 28, 2, 1900, 0, 0, 0, 1);
        send_fields(FUNC_ADD, 29, 2, 2024, 0, 0, 0, 365);
        send_fields(FUNC_ADD, 31, 12, 1999, 0, 0, 0, 1);
        // add: invalid date a
        send_fields(FUNC_ADD, 0, 1, 2000, 1, 1, 1, 5);
        send_fields(FUNC_ADD, 31, 4, 2000, 1, 1, 1, 5);
        send_fields(FUNC_ADD, 29, 2, 1900, 1, 1, 1, 5);
        send_fields(FUNC_ADD, 1, 0, 2000, 1, 1, 1, 5);
        send_fields(FUNC_ADD, 1, 13, 2000, 1, 1, 1, 5);
        send_fields(FUNC_ADD, 31, 15, 16383, 31, 15, 16383, 'hFFFFF);
        send_fields(FUNC_ADD, 1, 1, 0, 1, 1, 1, 5);
        send_fields(FUNC_ADD, 1, 1, 10000, 1, 1, 1, 5);
        // difference: both orders, leap span, invalid a or b
        send_fields(FUNC_DIFF, 15, 6, 2020, 15, 6, 2020, 0);
        send_fields(FUNC_DIFF, 31, 12, 9999, 1, 1, 1, 0);
        send_fields(FUNC_DIFF, 1, 1, 1, 31, 12, 9999, 'hFFFFF);
        send_fields(FUNC_DIFF, 1, 3, 2000, 28, 2, 2000, 0);
        send_fields(FUNC_DIFF, 1, 1, 2000, 30, 2, 2000, 0);
        send_fields(FUNC_DIFF, 31, 15, 16383, 1, 1, 2000, 0);
        send_fields(FUNC_DIFF, 10, 10, 2010, 31, 15, 16383, 0);
        send_fields(FUNC_DIFF, 0, 0, 0, 0, 0, 0, 0);

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 600 || i == 1500)
                drain_results();
            // back-to-back stretch
            if (!(i >= 900 && i < 1200) && $urandom_range(0, 99) < 14)
                idle_cycles($urandom_range(1, 12));
            apply_request(random_request());
        end
        idle_cycles(1);

        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (48) @(posedge clk);

        $display("covered %0d add and %0d difference transactions in %0d cycles",
                 board.add_count, board.diff_count, cycle_count);
        $display("of which %0d had an invalid date and %0d ran past the last year",
                 board.invalid_count, board.overflow_count);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("gregorian_date_arithmetic_top verification clean");
        else
            $display("gregorian_date_arithmetic_top verification failed");
        $finish;
    end

endmodule
